### design/epe_pkg.sv
`timescale 1ns / 1ps
package epe_pkg;
	localparam int FRAC_BITS = 20;
	localparam int CORDIC_ITERS = 24;
	localparam int PHASE_SH = 8 + FRAC_BITS;
	localparam logic [37:0] PHASE_K = 38'd174992710548;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

	function automatic logic signed [33:0] atan_tab(input int i);
		logic signed [33:0] t;
		case (i)
			0: t = 34'sd536870912;
			1: t = 34'sd316933406;
			2: t = 34'sd167458907;
			3: t = 34'sd85004756;
			4: t = 34'sd42667331;
			5: t = 34'sd21354465;
			6: t = 34'sd10679838;
			7: t = 34'sd5340245;
			8: t = 34'sd2670163;
			9: t = 34'sd1335087;
			10: t = 34'sd667544;
			11: t = 34'sd333772;
			12: t = 34'sd166886;
			13: t = 34'sd83443;
			14: t = 34'sd41722;
			15: t = 34'sd20861;
			16: t = 34'sd10430;
			17: t = 34'sd5215;
			18: t = 34'sd2608;
			19: t = 34'sd1304;
			20: t = 34'sd652;
			21: t = 34'sd326;
			22: t = 34'sd163;
			default: t = 34'sd81;
		endcase
		return t;
	endfunction

	function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > ONE_Q30) r = ONE_Q30[31:0];
		else if (v < -ONE_Q30) r = -ONE_Q30[31:0];
		else r = v[31:0];
		return r;
	endfunction
endpackage

### design/epe_cordic.sv
`timescale 1ns / 1ps
// Pipelined sine/cosine: one phase stage, one CORDIC iteration per stage,
// then a quadrant fold.
module epe_cordic import epe_pkg::*; (
	input  logic               clk,
	input  logic signed [22:0] angle,
	output logic signed [31:0] sin_q30,
	output logic signed [31:0] cos_q30
);
	logic [22:0] mag;
	logic [60:0] prod;
	logic [31:0] p;
	logic [1:0]  q;
	logic [31:0] ru;
	logic signed [33:0] x_s [CORDIC_ITERS+1];
	logic signed [33:0] y_s [CORDIC_ITERS+1];
	logic signed [33:0] z_s [CORDIC_ITERS+1];
	logic [1:0] q_s [CORDIC_ITERS+1];

	always_comb begin
		mag = angle[22] ? 23'(-angle) : angle;
		prod = 61'(mag) * 61'(PHASE_K) + (61'(1) << (PHASE_SH - 1));
		p = 32'(prod >> PHASE_SH);
		if (angle[22]) p = 32'(0) - p;
		q = 2'((p + 32'h2000_0000) >> 30);
		ru = p - ({30'd0, q} << 30);
	end

	always_ff @(posedge clk) begin
		x_s[0] <= CORDIC_GAIN;
		y_s[0] <= '0;
		z_s[0] <= 34'(signed'(ru));
		q_s[0] <= q;
	end

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (!z_s[i][33]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_tab(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_tab(i);
			end
			q_s[i+1] <= q_s[i];
		end
	end

	always_ff @(posedge clk) begin
		case (q_s[CORDIC_ITERS])
			2'd0: begin
				cos_q30 <= clamp_one(x_s[CORDIC_ITERS]);
				sin_q30 <= clamp_one(y_s[CORDIC_ITERS]);
			end
			2'd1: begin
				cos_q30 <= clamp_one(-y_s[CORDIC_ITERS]);
				sin_q30 <= clamp_one(x_s[CORDIC_ITERS]);
			end
			2'd2: begin
				cos_q30 <= clamp_one(-x_s[CORDIC_ITERS]);
				sin_q30 <= clamp_one(-y_s[CORDIC_ITERS]);
			end
			default: begin
				cos_q30 <= clamp_one(y_s[CORDIC_ITERS]);
				sin_q30 <= clamp_one(-x_s[CORDIC_ITERS]);
			end
		endcase
	end
endmodule

### design/epe_delay.sv
`timescale 1ns / 1ps
// Carries the item's differences alongside the trig pipeline.
module epe_delay import epe_pkg::*; (
	input  logic               clk,
	input  logic [31:0]        px_in,
	input  logic [31:0]        py_in,
	input  logic [31:0]        pz_in,
	input  logic signed [23:0] dr_in,
	input  logic signed [23:0] dp_in,
	input  logic signed [23:0] dy_in,
	output logic [31:0]        px_out,
	output logic [31:0]        py_out,
	output logic [31:0]        pz_out,
	output logic signed [23:0] dr_out,
	output logic signed [23:0] dp_out,
	output logic signed [23:0] dy_out
);
	localparam int DEPTH = CORDIC_ITERS + 2;
	logic [31:0] px_s [DEPTH];
	logic [31:0] py_s [DEPTH];
	logic [31:0] pz_s [DEPTH];
	logic signed [23:0] dr_s [DEPTH];
	logic signed [23:0] dp_s [DEPTH];
	logic signed [23:0] dy_s [DEPTH];

	always_ff @(posedge clk) begin
		px_s[0] <= px_in; py_s[0] <= py_in; pz_s[0] <= pz_in;
		dr_s[0] <= dr_in; dp_s[0] <= dp_in; dy_s[0] <= dy_in;
		for (int i = 1; i < DEPTH; i++) begin
			px_s[i] <= px_s[i-1]; py_s[i] <= py_s[i-1]; pz_s[i] <= pz_s[i-1];
			dr_s[i] <= dr_s[i-1]; dp_s[i] <= dp_s[i-1]; dy_s[i] <= dy_s[i-1];
		end
	end

	assign px_out = px_s[DEPTH-1];
	assign py_out = py_s[DEPTH-1];
	assign pz_out = pz_s[DEPTH-1];
	assign dr_out = dr_s[DEPTH-1];
	assign dp_out = dp_s[DEPTH-1];
	assign dy_out = dy_s[DEPTH-1];
endmodule

### design/euler_pose_error.sv
`timescale 1ns / 1ps
// Pose error A minus B with Euler-rate Jacobian on the angle differences.
// Fully pipelined: busy is never high, a new beat may start every cycle, and
// each result appears with done high.
// Latency is set by the 24-stage CORDIC pair plus phase, fold and two
// multiply stages. The receiver cannot stall; results must be taken.
module euler_pose_error import epe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] pose_a_x,
	input  logic signed [31:0] pose_a_y,
	input  logic signed [31:0] pose_a_z,
	input  logic signed [22:0] pose_a_roll,
	input  logic signed [22:0] pose_a_pitch,
	input  logic signed [22:0] pose_a_yaw,
	input  logic signed [31:0] pose_b_x,
	input  logic signed [31:0] pose_b_y,
	input  logic signed [31:0] pose_b_z,
	input  logic signed [22:0] pose_b_roll,
	input  logic signed [22:0] pose_b_pitch,
	input  logic signed [22:0] pose_b_yaw,
	output logic               done,
	output logic signed [31:0] err_x,
	output logic signed [31:0] err_y,
	output logic signed [31:0] err_z,
	output logic signed [24:0] err_rot_x,
	output logic signed [24:0] err_rot_y,
	output logic signed [24:0] err_rot_z
);
	localparam int LAT = CORDIC_ITERS + 4;
	logic [LAT-1:0] vld_q;
	logic signed [31:0] sr, cr, sp, cp;
	logic [31:0] px, py, pz;
	logic signed [23:0] dr, dp, dy;

	function automatic logic [31:0] sat32(input logic signed [32:0] v);
		logic [31:0] r;
		if (v[32] != v[31]) r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [24:0] sat25(input logic signed [63:0] v);
		logic signed [24:0] r;
		if (v > 64'sd16777215) r = 25'sh0ffffff;
		else if (v < -64'sd16777216) r = 25'sh1000000;
		else r = v[24:0];
		return r;
	endfunction

	assign busy = 1'b0;

	epe_cordic u_roll (.clk, .angle(pose_b_roll), .sin_q30(sr), .cos_q30(cr));
	epe_cordic u_pitch (.clk, .angle(pose_b_pitch), .sin_q30(sp), .cos_q30(cp));

	epe_delay u_dly (
		.clk,
		.px_in(sat32(33'(pose_a_x) - 33'(pose_b_x))),
		.py_in(sat32(33'(pose_a_y) - 33'(pose_b_y))),
		.pz_in(sat32(33'(pose_a_z) - 33'(pose_b_z))),
		.dr_in(24'(pose_a_roll) - 24'(pose_b_roll)),
		.dp_in(24'(pose_a_pitch) - 24'(pose_b_pitch)),
		.dy_in(24'(pose_a_yaw) - 24'(pose_b_yaw)),
		.px_out(px), .py_out(py), .pz_out(pz),
		.dr_out(dr), .dp_out(dp), .dy_out(dy)
	);

	// Stage A: coupled terms sin(r)cos(p), cos(r)cos(p), and the plain products.
	logic signed [31:0] scp_s1, ccp_s1;
	logic signed [63:0] crdp_s1, srdp_s1, spdy_s1;
	logic signed [23:0] dr_s1, dy_s1;
	logic [31:0] px_s1, py_s1, pz_s1;
	always_ff @(posedge clk) begin
		scp_s1 <= 32'((64'(sr) * 64'(cp) + 64'sd536870912) >>> 30);
		ccp_s1 <= 32'((64'(cr) * 64'(cp) + 64'sd536870912) >>> 30);
		crdp_s1 <= 64'(cr) * 64'(dp);
		srdp_s1 <= 64'(sr) * 64'(dp);
		spdy_s1 <= 64'(sp) * 64'(dy);
		dr_s1 <= dr; dy_s1 <= dy;
		px_s1 <= px; py_s1 <= py; pz_s1 <= pz;
	end

	// Stage B: second products, sum and single rounding.
	always_ff @(posedge clk) begin
		err_rot_x <= sat25(64'(dr_s1) + ((spdy_s1 + 64'sd536870912) >>> 30));
		err_rot_y <= sat25((crdp_s1 - 64'(scp_s1) * 64'(dy_s1) + 64'sd536870912) >>> 30);
		err_rot_z <= sat25((srdp_s1 + 64'(ccp_s1) * 64'(dy_s1) + 64'sd536870912) >>> 30);
		err_x <= px_s1; err_y <= py_s1; err_z <= pz_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT-2:0], start};
	end
	assign done = vld_q[LAT-1];

`ifndef SYNTH
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT)) else $error("done without start");
	a_lat2: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start, LAT) && $past(arst_n, LAT) |-> done) else $error("start lost");
	a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
`endif
endmodule
